// ----- src/kqt_pkg.sv -----
// shared types and constants of the keyed quantity table
package kqt_pkg;

  localparam int unsigned SLOTS   = 32;
  localparam int unsigned IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W   = $clog2(SLOTS + 1);
  localparam int unsigned KEY_W   = 8;
  localparam int unsigned AMT_W   = 8;
  localparam int unsigned USED_W  = 6;
  localparam int unsigned KLIM_W  = 9;
  localparam int unsigned CIDX_W  = 2;
  localparam int unsigned CDATA_W = 9;

  localparam logic [KLIM_W-1:0] KEY_LIMIT_RST   = 9'd256;
  localparam logic [AMT_W-1:0]  STACK_LIMIT_RST = 8'd99;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_e;

  typedef enum logic [CIDX_W-1:0] {
    CFG_KEY_LIMIT   = 2'd0,
    CFG_STACK_LIMIT = 2'd1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_EXEC  = 4'b0100,
    ST_SHIFT = 4'b1000
  } state_e;

endpackage

// ----- src/keyed_quantity_table.sv -----
// keyed quantity table: packed (key, quantity) store with add, remove and query
//
//  channel   signals                                        beat taken when
//  command   start, busy, cmd_i, item_key_i, amount_i       start && !busy
//  result    result_valid_o, ok_o, held_o, used_slots_o     result_valid_o (one cycle)
//  config    cfg_valid_i, cfg_ready_o, cfg_index_i,         cfg_valid_i && cfg_ready_o
//            cfg_data_i
//
// a command runs through a scan, an execute step and, for a deleting remove, a
// shift-down before its result strobe: the scan goes over the occupied entries (one
// entry a cycle through the single key comparator), the shift-down moves the later
// entries down one slot (one entry a cycle through the single table write port) and
// clears the freed last slot; a deleting remove scans only up to its hit
// reset clears the table, the fill count and loads the limit defaults at once
// the result is shown for one cycle only; the receiver cannot stall it
// busy rises after the accepted beat and stays high until the result cycle
module keyed_quantity_table
  import kqt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // command
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cmd_i,
  input  logic [KEY_W-1:0]   item_key_i,
  input  logic [AMT_W-1:0]   amount_i,
  // result
  output logic               result_valid_o,
  output logic               ok_o,
  output logic [AMT_W-1:0]   held_o,
  output logic [USED_W-1:0]  used_slots_o,
  // configuration
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CIDX_W-1:0]  cfg_index_i,
  input  logic [CDATA_W-1:0] cfg_data_i
);

  // limits
  logic [KLIM_W-1:0] key_limit_q;
  logic [AMT_W-1:0]  stack_limit_q;

  // table, kept packed in insertion order
  logic [KEY_W-1:0]  keys_q [SLOTS];
  logic [AMT_W-1:0]  amts_q [SLOTS];
  logic [CNT_W-1:0]  fill_q, fill_d;

  // sequencer
  state_e            state_q, state_d;
  logic [CNT_W-1:0]  ptr_q, ptr_d;
  logic [IDX_W-1:0]  ptr_idx;

  // latched command
  logic [1:0]        cmd_q;
  logic [KEY_W-1:0]  key_q;
  logic [AMT_W-1:0]  amt_q;

  // scan outcome
  logic              found_q, found_d;
  logic [IDX_W-1:0]  pos_q, pos_d;
  logic [AMT_W-1:0]  hit_q, hit_d;

  // single table write port
  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  logic [KEY_W-1:0]  wr_key;
  logic [AMT_W-1:0]  wr_amt;

  // result registers
  logic              res_vld_q, res_vld_d;
  logic              ok_q, ok_d;
  logic [AMT_W-1:0]  held_q, held_d;
  logic [USED_W-1:0] used_q, used_d;

  // shared arithmetic
  logic              arg_ok;
  logic [AMT_W:0]    sum;
  logic [AMT_W-1:0]  diff;
  logic [CNT_W-1:0]  fill_dec;
  logic [AMT_W-1:0]  held_fb;
  logic              accept;

  assign accept      = start && !busy;
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign ptr_idx     = ptr_q[IDX_W-1:0];

  assign arg_ok   = (key_q != '0) && ({1'b0, key_q} < key_limit_q) && (amt_q != '0);
  assign sum      = {1'b0, hit_q} + {1'b0, amt_q};
  assign diff     = hit_q - amt_q;
  assign fill_dec = fill_q - CNT_W'(1);
  assign held_fb  = found_q ? hit_q : '0;

  // limit registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_limit_q   <= KEY_LIMIT_RST;
      stack_limit_q <= STACK_LIMIT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_KEY_LIMIT:   key_limit_q   <= cfg_data_i;
        CFG_STACK_LIMIT: stack_limit_q <= cfg_data_i[AMT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer next state
  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    fill_d    = fill_q;
    found_d   = found_q;
    pos_d     = pos_q;
    hit_d     = hit_q;
    wr_en     = 1'b0;
    wr_idx    = pos_q;
    wr_key    = key_q;
    wr_amt    = amt_q;
    res_vld_d = 1'b0;
    ok_d      = ok_q;
    held_d    = held_q;
    used_d    = used_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ptr_d   = '0;
          found_d = 1'b0;
          state_d = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (ptr_q >= fill_q) begin
          state_d = ST_EXEC;
        end else if ((key_q != '0) && (keys_q[ptr_idx] == key_q)) begin
          found_d = 1'b1;
          pos_d   = ptr_idx;
          hit_d   = amts_q[ptr_idx];
          state_d = ST_EXEC;
        end else begin
          ptr_d = ptr_q + CNT_W'(1);
        end
      end

      ST_EXEC: begin
        res_vld_d = 1'b1;
        ok_d      = 1'b0;
        held_d    = held_fb;
        used_d    = USED_W'(fill_q);
        state_d   = ST_IDLE;
        case (cmd_q)
          CMD_ADD: begin
            if (arg_ok) begin
              if (found_q) begin
                if (sum <= {1'b0, stack_limit_q}) begin
                  wr_en  = 1'b1;
                  wr_amt = sum[AMT_W-1:0];
                  ok_d   = 1'b1;
                  held_d = sum[AMT_W-1:0];
                end
              end else if (fill_q < CNT_W'(SLOTS)) begin
                // append after the last occupied entry
                wr_en  = 1'b1;
                wr_idx = fill_q[IDX_W-1:0];
                fill_d = fill_q + CNT_W'(1);
                ok_d   = 1'b1;
                held_d = amt_q;
                used_d = USED_W'(fill_q + CNT_W'(1));
              end
            end
          end
          CMD_REMOVE: begin
            if (arg_ok && found_q && (hit_q >= amt_q)) begin
              ok_d = 1'b1;
              if (diff != '0) begin
                wr_en  = 1'b1;
                wr_amt = diff;
                held_d = diff;
              end else begin
                // emptied entry: close the gap before reporting
                res_vld_d = 1'b0;
                ptr_d     = CNT_W'(pos_q) + CNT_W'(1);
                state_d   = ST_SHIFT;
              end
            end
          end
          CMD_QUERY: ok_d = found_q;
          default: ;
        endcase
      end

      ST_SHIFT: begin
        if (ptr_q < fill_q) begin
          wr_en  = 1'b1;
          wr_idx = ptr_idx - IDX_W'(1);
          wr_key = keys_q[ptr_idx];
          wr_amt = amts_q[ptr_idx];
          ptr_d  = ptr_q + CNT_W'(1);
        end else begin
          // clear the freed last slot and report
          wr_en     = 1'b1;
          wr_idx    = fill_dec[IDX_W-1:0];
          wr_key    = '0;
          wr_amt    = '0;
          fill_d    = fill_dec;
          res_vld_d = 1'b1;
          ok_d      = 1'b1;
          held_d    = '0;
          used_d    = USED_W'(fill_dec);
          state_d   = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ptr_q     <= '0;
      fill_q    <= '0;
      found_q   <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ptr_q     <= ptr_d;
      fill_q    <= fill_d;
      found_q   <= found_d;
      res_vld_q <= res_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
      key_q <= item_key_i;
      amt_q <= amount_i;
    end
    pos_q  <= pos_d;
    hit_q  <= hit_d;
    ok_q   <= ok_d;
    held_q <= held_d;
    used_q <= used_d;
  end

  // table storage, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        keys_q[i] <= '0;
        amts_q[i] <= '0;
      end
    end else if (wr_en) begin
      keys_q[wr_idx] <= wr_key;
      amts_q[wr_idx] <= wr_amt;
    end
  end

  assign result_valid_o = res_vld_q;
  assign ok_o           = ok_q;
  assign held_o         = held_q;
  assign used_slots_o   = used_q;

  // fill count never passes the table size
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(SLOTS))
    else $error("fill count beyond table size");

  // scan pointer never passes the fill count
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (ptr_q <= fill_q))
    else $error("scan pointer past fill count");

  // an accepted beat makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted command did not raise busy");

  // a result comes only from the final step of a command
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(state_q) == ST_EXEC || $past(state_q) == ST_SHIFT))
    else $error("result strobe without a finishing step");

  // the result strobe lasts one cycle
  a_result_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

endmodule
